// ===== rtl/heat_colormap_with_density_alpha_assert.svh =====
// ----------------------------------------------------------------------------
// Heat colormap assertion macros
// Shared concurrent assertion forms for the heat colormap checkers.
// ----------------------------------------------------------------------------
`ifndef HEAT_COLORMAP_WITH_DENSITY_ALPHA_ASSERT_SVH
`define HEAT_COLORMAP_WITH_DENSITY_ALPHA_ASSERT_SVH

// Checked only while out of reset.
`define HCM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Heat colormap package
// Widths, constants, codes and the small arithmetic helpers of the colormap.
// ----------------------------------------------------------------------------
package hcm_pkg;

  localparam int FRAC_BITS = 8;
  localparam int TEMP_W    = 16;
  localparam int DENS_W    = 16;
  localparam int MODE_W    = 2;
  localparam int PIXEL_W   = 32;
  localparam int CHAN_W    = 8;

  // Full scale 40.0 in raw units is 5 << SEG_SH.
  localparam int SEG_SH = FRAC_BITS + 3;
  localparam int REM_W  = SEG_SH + 3;
  localparam int NUM_W  = SEG_SH + 4;
  localparam int X_W    = TEMP_W + 2;
  localparam int XHI_W  = X_W - SEG_SH;
  localparam int SEG_W  = 3;
  localparam int V_W    = 12;
  localparam int PROD_W = NUM_W + CHAN_W;
  localparam int DCMP_W = (DENS_W > NUM_W) ? DENS_W : NUM_W;

  // floor(v / 5) = (v * RCP_DIV5) >> RCP_SH, exact for v < 2**14.
  localparam int RCP_SH = 16;
  localparam int RCP_W  = 14;
  localparam logic [RCP_W-1:0] RCP_DIV5 = RCP_W'((1 << RCP_SH) / 5 + 1);

  localparam logic [NUM_W-1:0] FULL  = NUM_W'(5) << SEG_SH;
  localparam logic [NUM_W-1:0] FULL2 = NUM_W'(5) << (SEG_SH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TEMP = 2'd0,
    MODE_DENS = 2'd1,
    MODE_BOTH = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [SEG_W-1:0] {
    SEG_PURPLE = 3'd0,
    SEG_BLUE   = 3'd1,
    SEG_GREEN  = 3'd2,
    SEG_YELLOW = 3'd3,
    SEG_ORANGE = 3'd4,
    SEG_RED    = 3'd5,
    SEG_FADE   = 3'd6,
    SEG_WHITE  = 3'd7
  } seg_e;

  function automatic logic [V_W-1:0] div5(input logic [V_W-1:0] v);
    logic [V_W+RCP_W-1:0] p;
    p = (V_W+RCP_W)'(v) * (V_W+RCP_W)'(RCP_DIV5);
    return V_W'(p >> RCP_SH);
  endfunction

  // floor(255 * num / 2**(SEG_SH + half)); a later div5 completes the ramp.
  function automatic logic [V_W-1:0] ramp_v(input logic [NUM_W-1:0] num,
                                            input logic half);
    logic [PROD_W-1:0] p;
    p = {num, CHAN_W'(0)} - PROD_W'(num);
    return half ? V_W'(p >> (SEG_SH + 1)) : V_W'(p >> SEG_SH);
  endfunction

endpackage

// ===== rtl/hcm_pix_in_if.sv =====
// ----------------------------------------------------------------------------
// Heat colormap pixel input channel
// Valid/ready channel carrying temperature, density and end of frame.
// ----------------------------------------------------------------------------
interface hcm_pix_in_if import hcm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [DENS_W-1:0] density;
  logic                     end_of_frame;

  modport source (output valid, temperature, density, end_of_frame, input ready);
  modport sink   (input valid, temperature, density, end_of_frame, output ready);
endinterface

// ===== rtl/hcm_pix_out_if.sv =====
// ----------------------------------------------------------------------------
// Heat colormap pixel output channel
// Valid/ready channel carrying the packed RGBA word and the frame flag.
// ----------------------------------------------------------------------------
interface hcm_pix_out_if import hcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_done;

  modport source (output valid, pixel, frame_done, input ready);
  modport sink   (input valid, pixel, frame_done, output ready);
endinterface

// ===== rtl/hcm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Heat colormap configuration channel
// Valid/ready write channel for the mode register.
// ----------------------------------------------------------------------------
interface hcm_cfg_if import hcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/heat_colormap_with_density_alpha.sv =====
// ----------------------------------------------------------------------------
// Heat colormap with density alpha
// Temperature and density samples in, packed RGBA8888 pixels out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock while the output is
// not stalled. The four register stages (scale, segment split, ramp numerators,
// divide by five and pack) each hold one pixel, so a stalled output fills the
// pipeline before pix_i.ready drops. The mode register is written through
// cfg_i, which is always ready; write it only while no pixel is in flight.
// Reset mode is temperature color with density alpha.
module heat_colormap_with_density_alpha import hcm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  hcm_cfg_if.sink       cfg_i,
  hcm_pix_in_if.sink    pix_i,
  hcm_pix_out_if.source pix_o
);

  mode_e mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BOTH;
    end else if (cfg_i.valid) begin
      mode_q <= mode_e'(cfg_i.data);
    end
  end

  hcm_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .pix_i  (pix_i),
    .pix_o  (pix_o)
  );

endmodule

// ===== rtl/hcm_pipe.sv =====
// ----------------------------------------------------------------------------
// Heat colormap pipeline
// Four register stages: scale, segment split, ramp numerators, byte divide.
// ----------------------------------------------------------------------------
module hcm_pipe import hcm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mode_e         mode_i,
  hcm_pix_in_if.sink    pix_i,
  hcm_pix_out_if.source pix_o
);

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;

  logic [X_W-1:0]    x1_q, x1_d;
  logic [NUM_W-1:0]  dn1_q, dn1_d;
  logic              eof1_q;

  seg_e              seg2_q, seg2_d;
  logic [REM_W-1:0]  rem2_q, rem2_d;
  logic [NUM_W-1:0]  dn2_q;
  logic              eof2_q;

  logic [V_W-1:0]    vr3_q, vg3_q, vb3_q, va3_q;
  logic [V_W-1:0]    vr3_d, vg3_d, vb3_d, va3_d;
  logic              eof3_q;

  logic [PIXEL_W-1:0] pix_q, pix_d;
  logic               eofo_q;

  assign en_o = !vo_q || pix_o.ready;
  assign en3  = !v3_q || en_o;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= pix_i.valid;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  // Stage 1: clamp, x = 7 * t, density clamp.
  always_comb begin
    logic [X_W-1:0]    t;
    logic [DCMP_W-1:0] d;
    t = pix_i.temperature[TEMP_W-1] ? '0 : X_W'(pix_i.temperature[TEMP_W-2:0]);
    x1_d = (t << 3) - t;
    d = DCMP_W'(pix_i.density[DENS_W-2:0]);
    if (pix_i.density[DENS_W-1]) begin
      dn1_d = '0;
    end else if (d > DCMP_W'(FULL)) begin
      dn1_d = FULL;
    end else begin
      dn1_d = NUM_W'(d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q   <= x1_d;
      dn1_q  <= dn1_d;
      eof1_q <= pix_i.end_of_frame;
    end
  end

  // Stage 2: segment = floor(x / 40.0), remainder inside it.
  always_comb begin
    logic [V_W-1:0] xhi;
    logic [V_W-1:0] q;
    logic [V_W-1:0] rhi;
    xhi = V_W'(x1_q[X_W-1:SEG_SH]);
    q   = div5(xhi);
    rhi = xhi - ((q << 2) + q);
    seg2_d = (q > V_W'(SEG_WHITE)) ? SEG_WHITE : seg_e'(q[SEG_W-1:0]);
    rem2_d = {rhi[2:0], x1_q[SEG_SH-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      seg2_q <= seg2_d;
      rem2_q <= rem2_d;
      dn2_q  <= dn1_q;
      eof2_q <= eof1_q;
    end
  end

  // Stage 3: per-channel numerator, times 255, scaled down by a power of two.
  always_comb begin
    logic [NUM_W-1:0] rem, drem, d2rem;
    logic [NUM_W-1:0] rn, gn, bn;
    logic             rh, gh;
    rem   = NUM_W'(rem2_q);
    drem  = FULL - rem;
    d2rem = FULL2 - rem;
    rn = '0;
    gn = '0;
    bn = '0;
    rh = 1'b0;
    gh = 1'b0;
    case (seg2_q)
      SEG_PURPLE: begin rn = rem;  rh = 1'b1; bn = rem;  end
      SEG_BLUE:   begin rn = drem; rh = 1'b1; bn = FULL; end
      SEG_GREEN:  begin gn = rem;  bn = drem;            end
      SEG_YELLOW: begin rn = rem;  gn = FULL;            end
      SEG_ORANGE: begin rn = FULL; gn = d2rem; gh = 1'b1; end
      SEG_RED:    begin rn = FULL; gn = drem;  gh = 1'b1; end
      SEG_FADE:   begin rn = FULL; gn = rem;   bn = rem; end
      default:    begin rn = FULL; gn = FULL;  bn = FULL; end
    endcase
    vr3_d = ramp_v(rn, rh);
    vg3_d = ramp_v(gn, gh);
    vb3_d = ramp_v(bn, 1'b0);
    va3_d = ramp_v(dn2_q, 1'b0);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      vr3_q  <= vr3_d;
      vg3_q  <= vg3_d;
      vb3_q  <= vb3_d;
      va3_q  <= va3_d;
      eof3_q <= eof2_q;
    end
  end

  // Stage 4: divide by 5, pack by mode.
  always_comb begin
    logic [CHAN_W-1:0] r, g, b, a;
    r = CHAN_W'(div5(vr3_q));
    g = CHAN_W'(div5(vg3_q));
    b = CHAN_W'(div5(vb3_q));
    a = CHAN_W'(div5(va3_q));
    case (mode_i)
      MODE_TEMP: pix_d = {r, g, b, {CHAN_W{1'b1}}};
      MODE_DENS: pix_d = {{(3*CHAN_W){1'b1}}, a};
      MODE_BOTH: pix_d = {r, g, b, a};
      default:   pix_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      pix_q  <= pix_d;
      eofo_q <= eof3_q;
    end
  end

  assign pix_o.valid      = vo_q;
  assign pix_o.pixel      = pix_q;
  assign pix_o.frame_done = eofo_q;

endmodule

// ===== rtl/hcm_checker.sv =====
// ----------------------------------------------------------------------------
// Heat colormap port checker
// Watches the top-level channels for reset, stall and latency behavior.
// ----------------------------------------------------------------------------
`include "heat_colormap_with_density_alpha_assert.svh"

module hcm_checker import hcm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [PIXEL_W-1:0] out_pixel_i,
  input logic               out_frame_done_i
);

  `HCM_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_i, "output beat during reset")

  `HCM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i) && $stable(out_frame_done_i), "stalled output beat changed")

  `HCM_ASSERT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_i, "pixel not out after four cycles")

endmodule

bind heat_colormap_with_density_alpha hcm_checker u_hcm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (pix_i.valid),
  .in_ready_i       (pix_i.ready),
  .out_valid_i      (pix_o.valid),
  .out_ready_i      (pix_o.ready),
  .out_pixel_i      (pix_o.pixel),
  .out_frame_done_i (pix_o.frame_done)
);
